// ===== rtl/core/bga_pkg.sv =====
// Shared types, constants and the sequencer microcode of the battery gauge averager.
`timescale 1ns / 1ps

package bga_pkg;

  // Window length in samples (1 to 16)
  localparam int unsigned SAMPLES = 10;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CNT_W      = $clog2(SAMPLES + 1);
  localparam int unsigned MV_OUT_W   = 15;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned RATIO_W    = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Datapath widths
  localparam int unsigned QUO_W  = 16;             // average and ADC millivolts
  localparam int unsigned XW     = 28;             // dividend and product register
  localparam int unsigned REM_W  = 13;             // remainder, below twice the divisor
  localparam int unsigned MV_W   = XW - 8;         // battery millivolts before the output cut

  // Reciprocal of SAMPLES: estimate is never high and at most one low
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_S = RECIP_W'((64'd1 << RECIP_SHIFT) / SAMPLES);

  // ADC scaling: full scale is 2^12-1, reference 3300 mV
  localparam int unsigned ADC_FS_SHIFT = 12;
  localparam logic [REM_W-1:0] ADC_FULL_SCALE = REM_W'((1 << ADC_FS_SHIFT) - 1);
  localparam logic [XW-1:0]    ADC_REF_MV     = XW'(3300);
  localparam int unsigned      ADC_EST_W      = XW + ADC_FS_SHIFT + 1;
  localparam int unsigned      ADC_EST_SHIFT  = 2 * ADC_FS_SHIFT;

  // Charge curve knees, millivolts
  localparam logic [MV_W-1:0] KNEE_FULL_MV  = MV_W'(4000);
  localparam logic [MV_W-1:0] KNEE_MID_MV   = MV_W'(3700);
  localparam logic [MV_W-1:0] KNEE_EMPTY_MV = MV_W'(3300);
  localparam logic [PCT_W-1:0] PCT_FULL     = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_MID      = PCT_W'(50);
  // x/6 as (x*171)>>10, exact below the 300 mV span of the upper segment
  localparam int unsigned      MID_D_W      = 9;
  localparam logic [7:0]       DIV6_RECIP   = 8'd171;
  localparam int unsigned      DIV6_SHIFT   = 10;

  localparam logic [MV_OUT_W-1:0] RST_RATIO    = MV_OUT_W'(512);
  localparam logic [MV_OUT_W-1:0] RST_CRITICAL = MV_OUT_W'(3300);
  localparam logic [MV_OUT_W-1:0] RST_LOW      = MV_OUT_W'(3500);
  localparam logic [MV_OUT_W-1:0] RST_PRESENT  = MV_OUT_W'(2500);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_LOW        = 3'd1,
    ST_CRITICAL   = 3'd2,
    ST_NO_BATTERY = 3'd3,
    ST_NO_CIRCUIT = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIVIDER_RATIO = 3'd0,
    REG_CRITICAL_MV   = 3'd1,
    REG_LOW_MV        = 3'd2,
    REG_PRESENT_MV    = 3'd3,
    REG_CIRCUIT       = 3'd4
  } cfg_idx_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_AVG_EST,
    OP_AVG_REM,
    OP_INC,
    OP_SCALE,
    OP_ADC_EST,
    OP_ADC_REM,
    OP_RATIO,
    OP_FINISH
  } op_e;

  // Sequencer flow control
  typedef enum logic [1:0] {
    J_NEXT,
    J_SKIP_AVG,
    J_SKIP_ADC,
    J_DONE
  } jump_e;

  localparam int unsigned PC_W       = 4;
  localparam int unsigned UCODE_LEN  = 11;

  typedef struct packed {
    op_e              op;
    jump_e            jump;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic busy;
  } seq_ctrl_t;

  typedef struct packed {
    logic rem_lt_avg;
    logic rem_lt_adc;
    logic out_busy;
  } seq_flags_t;

  localparam logic [PC_W-1:0] PC_SCALE = PC_W'(4);
  localparam logic [PC_W-1:0] PC_RATIO = PC_W'(9);

  // End-of-window program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, jump: J_DONE, target: '0};
    unique case (pc)
      4'd0:    w = '{op: OP_AVG_EST, jump: J_NEXT,     target: '0};
      4'd1:    w = '{op: OP_AVG_REM, jump: J_NEXT,     target: '0};
      4'd2:    w = '{op: OP_NOP,     jump: J_SKIP_AVG, target: PC_SCALE};
      4'd3:    w = '{op: OP_INC,     jump: J_NEXT,     target: '0};
      4'd4:    w = '{op: OP_SCALE,   jump: J_NEXT,     target: '0};
      4'd5:    w = '{op: OP_ADC_EST, jump: J_NEXT,     target: '0};
      4'd6:    w = '{op: OP_ADC_REM, jump: J_NEXT,     target: '0};
      4'd7:    w = '{op: OP_NOP,     jump: J_SKIP_ADC, target: PC_RATIO};
      4'd8:    w = '{op: OP_INC,     jump: J_NEXT,     target: '0};
      4'd9:    w = '{op: OP_RATIO,   jump: J_NEXT,     target: '0};
      4'd10:   w = '{op: OP_FINISH,  jump: J_DONE,     target: '0};
      default: w = '{op: OP_NOP,     jump: J_DONE,     target: '0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/bga_if.sv =====
// Valid/ready channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps

interface bga_sample_if;
  logic                              valid;
  logic                              ready;
  logic [bga_pkg::SAMPLE_W-1:0]      sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bga_result_if;
  logic                              valid;
  logic                              ready;
  logic [bga_pkg::MV_OUT_W-1:0]      battery_mv;
  logic [bga_pkg::PCT_W-1:0]         percent;
  logic [bga_pkg::STATUS_W-1:0]      status;
  modport source (output valid, output battery_mv, output percent, output status, input ready);
  modport sink   (input valid, input battery_mv, input percent, input status, output ready);
endinterface

interface bga_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bga_pkg::CFG_IDX_W-1:0]     index;
  logic [bga_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bga_seq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps.
`timescale 1ns / 1ps

module bga_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bga_pkg::seq_flags_t flags_i,
  output bga_pkg::seq_ctrl_t  ctrl_o
);

  logic                       run_q, run_d;
  logic [bga_pkg::PC_W-1:0]   pc_q, pc_d;
  bga_pkg::uword_t            word;
  logic                       stall;

  assign word  = bga_pkg::ucode(pc_q);
  // hold the last step while the result register is still occupied
  assign stall = (word.jump == bga_pkg::J_DONE) && flags_i.out_busy;

  always_comb begin
    run_d = run_q;
    pc_d  = pc_q;
    if (!run_q) begin
      if (start_i) begin
        run_d = 1'b1;
        pc_d  = '0;
      end
    end else begin
      unique case (word.jump)
        bga_pkg::J_NEXT:     pc_d = pc_q + 1'b1;
        bga_pkg::J_SKIP_AVG: pc_d = flags_i.rem_lt_avg ? word.target : pc_q + 1'b1;
        bga_pkg::J_SKIP_ADC: pc_d = flags_i.rem_lt_adc ? word.target : pc_q + 1'b1;
        bga_pkg::J_DONE: begin
          if (!stall) begin
            run_d = 1'b0;
          end
        end
        default:             pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pc_q  <= '0;
    end else begin
      run_q <= run_d;
      pc_q  <= pc_d;
    end
  end

  assign ctrl_o.op   = (run_q && !stall) ? word.op : bga_pkg::OP_NOP;
  assign ctrl_o.busy = run_q;

`ifndef SYNTH
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (pc_q < bga_pkg::PC_W'(bga_pkg::UCODE_LEN)))
    else $error("sequencer step outside the program");
`endif

endmodule

// ===== rtl/core/battery_gauge_averager_top.sv =====
// Top level of the battery gauge averager: accumulator, datapath and register file.
`timescale 1ns / 1ps

// Channel     Dir   Beat contents
// sample_i    in    sample[11:0] raw ADC conversion
// result_o    out   battery_mv[14:0], percent[6:0], status[2:0]
// cfg_i       in    index[2:0], data[14:0] register write
//
// Samples are taken one per cycle; the beat that closes a window starts the
// end-of-window microcode program in the shared datapath. It runs nine to eleven
// steps (each increment step runs only when its quotient estimate is one low), and
// sample_i.ready is low during the program.
// The last step waits while an earlier result is still held on result_o.
// Reset clears the accumulator, the count, the registers to their defaults and
// the sequencer; register writes are always taken and read when the program runs.

module battery_gauge_averager_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  bga_sample_if.sink   sample_i,
  bga_result_if.source result_o,
  bga_cfg_if.sink      cfg_i
);

  // register file
  logic [bga_pkg::RATIO_W-1:0]    ratio_q;
  logic [bga_pkg::MV_OUT_W-1:0]   critical_q;
  logic [bga_pkg::MV_OUT_W-1:0]   low_q;
  logic [bga_pkg::MV_OUT_W-1:0]   present_q;
  logic                           circuit_q;

  // accumulator
  logic [bga_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [bga_pkg::CNT_W-1:0]      count_q;
  logic                           in_beat;
  logic                           win_end;

  // datapath
  logic [bga_pkg::XW-1:0]         x_q;
  logic [bga_pkg::QUO_W-1:0]      q_q;
  logic [bga_pkg::REM_W-1:0]      r_q;
  logic [bga_pkg::SUM_W+bga_pkg::RECIP_W-1:0] avg_prod;
  logic [bga_pkg::ADC_EST_W-1:0]  adc_est;
  logic [bga_pkg::XW-1:0]         avg_back;
  logic [bga_pkg::XW-1:0]         adc_back;

  // result stage
  logic [bga_pkg::MV_W-1:0]       mv;
  logic [bga_pkg::MV_W-1:0]       mid_diff;
  logic [bga_pkg::MV_W-1:0]       low_diff;
  logic [bga_pkg::MID_D_W+8-1:0]  mid_prod;
  logic [bga_pkg::PCT_W-1:0]      pct;
  bga_pkg::status_e               status;
  logic                           out_valid_q;
  logic [bga_pkg::MV_OUT_W-1:0]   out_mv_q;
  logic [bga_pkg::PCT_W-1:0]      out_pct_q;
  bga_pkg::status_e               out_status_q;

  bga_pkg::seq_ctrl_t             ctrl;
  bga_pkg::seq_flags_t            flags;

  // --- register writes -------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q    <= bga_pkg::RATIO_W'(bga_pkg::RST_RATIO);
      critical_q <= bga_pkg::RST_CRITICAL;
      low_q      <= bga_pkg::RST_LOW;
      present_q  <= bga_pkg::RST_PRESENT;
      circuit_q  <= 1'b1;
    end else if (cfg_i.valid) begin
      // drop writes beyond the register list
      unique case (cfg_i.index)
        bga_pkg::REG_DIVIDER_RATIO: ratio_q    <= cfg_i.data[bga_pkg::RATIO_W-1:0];
        bga_pkg::REG_CRITICAL_MV:   critical_q <= cfg_i.data;
        bga_pkg::REG_LOW_MV:        low_q      <= cfg_i.data;
        bga_pkg::REG_PRESENT_MV:    present_q  <= cfg_i.data;
        bga_pkg::REG_CIRCUIT:       circuit_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // --- sample accumulation ---------------------------------------------------
  // Take samples only while the sequencer is idle.
  assign sample_i.ready = !ctrl.busy;
  assign in_beat        = sample_i.valid && sample_i.ready;
  assign sum_d          = sum_q + bga_pkg::SUM_W'(sample_i.sample);
  assign win_end        = in_beat && (count_q == bga_pkg::CNT_W'(bga_pkg::SAMPLES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (in_beat) begin
      if (win_end) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_q + 1'b1;
      end
    end
  end

  // --- sequencer -------------------------------------------------------------
  assign flags.rem_lt_avg = r_q < bga_pkg::REM_W'(bga_pkg::SAMPLES);
  assign flags.rem_lt_adc = r_q < bga_pkg::ADC_FULL_SCALE;
  assign flags.out_busy   = out_valid_q && !result_o.ready;

  bga_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (win_end),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // --- datapath --------------------------------------------------------------
  // Quotient estimates: reciprocal multiply for /SAMPLES, shift-add for /4095.
  // Both are never high and at most one low; the remainder step and the
  // conditional increment correct them.
  assign avg_prod = bga_pkg::SUM_W'(x_q) * bga_pkg::RECIP_S;
  assign adc_est  = bga_pkg::ADC_EST_W'(x_q)
                  + (bga_pkg::ADC_EST_W'(x_q) << bga_pkg::ADC_FS_SHIFT);
  assign avg_back = bga_pkg::XW'(q_q) * bga_pkg::XW'(bga_pkg::SAMPLES);
  assign adc_back = (bga_pkg::XW'(q_q) << bga_pkg::ADC_FS_SHIFT) - bga_pkg::XW'(q_q);

  always_ff @(posedge clk_i) begin
    if (win_end) begin
      x_q <= bga_pkg::XW'(sum_d);
    end else begin
      unique case (ctrl.op)
        bga_pkg::OP_AVG_EST: q_q <= bga_pkg::QUO_W'(avg_prod >> bga_pkg::RECIP_SHIFT);
        bga_pkg::OP_AVG_REM: r_q <= bga_pkg::REM_W'(x_q - avg_back);
        bga_pkg::OP_INC:     q_q <= q_q + 1'b1;
        bga_pkg::OP_SCALE:   x_q <= bga_pkg::XW'(q_q) * bga_pkg::ADC_REF_MV;
        bga_pkg::OP_ADC_EST: q_q <= bga_pkg::QUO_W'(adc_est >> bga_pkg::ADC_EST_SHIFT);
        bga_pkg::OP_ADC_REM: r_q <= bga_pkg::REM_W'(x_q - adc_back);
        bga_pkg::OP_RATIO:   x_q <= bga_pkg::XW'(q_q) * bga_pkg::XW'(ratio_q);
        bga_pkg::OP_NOP,
        bga_pkg::OP_FINISH:  ;
        default:             ;
      endcase
    end
  end

  // --- percentage and status -------------------------------------------------
  // Q8 ratio product lies in x_q; drop the fraction bits.
  assign mv       = x_q[bga_pkg::XW-1:8];
  assign mid_diff = mv - bga_pkg::KNEE_MID_MV;
  assign low_diff = mv - bga_pkg::KNEE_EMPTY_MV;
  assign mid_prod = mid_diff[bga_pkg::MID_D_W-1:0] * bga_pkg::DIV6_RECIP;

  always_comb begin
    priority if (mv >= bga_pkg::KNEE_FULL_MV) begin
      pct = bga_pkg::PCT_FULL;
    end else if (mv >= bga_pkg::KNEE_MID_MV) begin
      pct = bga_pkg::PCT_MID + bga_pkg::PCT_W'(mid_prod >> bga_pkg::DIV6_SHIFT);
    end else if (mv >= bga_pkg::KNEE_EMPTY_MV) begin
      pct = bga_pkg::PCT_W'(low_diff >> 3);
    end else begin
      pct = '0;
    end
  end

  // Thresholds are checked in priority order; no ordering among their values is assumed.
  always_comb begin
    priority if (!circuit_q) begin
      status = bga_pkg::ST_NO_CIRCUIT;
    end else if (mv <= bga_pkg::MV_W'(present_q)) begin
      status = bga_pkg::ST_NO_BATTERY;
    end else if (mv <= bga_pkg::MV_W'(critical_q)) begin
      status = bga_pkg::ST_CRITICAL;
    end else if (mv <= bga_pkg::MV_W'(low_q)) begin
      status = bga_pkg::ST_LOW;
    end else begin
      status = bga_pkg::ST_OK;
    end
  end

  // --- result register -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == bga_pkg::OP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == bga_pkg::OP_FINISH) begin
      out_status_q <= status;
      unique case (status)
        bga_pkg::ST_NO_CIRCUIT: begin
          out_mv_q  <= '0;
          out_pct_q <= '0;
        end
        bga_pkg::ST_NO_BATTERY: begin
          out_mv_q  <= mv[bga_pkg::MV_OUT_W-1:0];
          out_pct_q <= '0;
        end
        default: begin
          out_mv_q  <= mv[bga_pkg::MV_OUT_W-1:0];
          out_pct_q <= pct;
        end
      endcase
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.battery_mv = out_mv_q;
  assign result_o.percent    = out_pct_q;
  assign result_o.status     = out_status_q;

`ifndef SYNTH
  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.busy |-> !in_beat)
    else $error("sample beat taken during the end-of-window program");

  a_sum_clear_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.busy |-> (sum_q == '0 && count_q == '0))
    else $error("accumulator not cleared for the next window");

  a_count_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < bga_pkg::CNT_W'(bga_pkg::SAMPLES))
    else $error("sample count beyond the window");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.op == bga_pkg::OP_FINISH))
    else $error("result raised without the final program step");

  a_finish_not_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == bga_pkg::OP_FINISH) |-> !(out_valid_q && !result_o.ready))
    else $error("pending result overwritten");
`endif

endmodule

// ===== verif/battery_gauge_averager_top_tb.sv =====
// Self-checking testbench for the battery gauge averager top level.
`timescale 1ns / 1ps

module battery_gauge_averager_top_tb;

  // Charge curve and ADC scaling as the gauge is specified
  localparam int unsigned VREF_MV       = 3300;
  localparam int unsigned ADC_FULL      = 4095;
  localparam int unsigned CURVE_FULL_MV = 4000;
  localparam int unsigned CURVE_MID_MV  = 3700;
  localparam int unsigned CURVE_LOW_MV  = 3300;
  localparam int unsigned MV_SPAN       = 26400;

  // Cycles to let pass once the last reading is in: the end-of-window
  // program is at most eleven steps, plus margin for a beat still in flight
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [bga_pkg::MV_OUT_W-1:0] mv;
    logic [bga_pkg::PCT_W-1:0]    pct;
    bga_pkg::status_e             st;
  } gauge_reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bga_sample_if smp ();
  bga_result_if res ();
  bga_cfg_if    cfg ();

  battery_gauge_averager_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp.sink),
    .result_o (res.source),
    .cfg_i    (cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Own copy of the gauge: registers, window accumulator and readings due
  logic [bga_pkg::RATIO_W-1:0]  ratio_q8;
  logic [bga_pkg::MV_OUT_W-1:0] critical_mv;
  logic [bga_pkg::MV_OUT_W-1:0] low_mv;
  logic [bga_pkg::MV_OUT_W-1:0] present_mv;
  logic                         circuit_fitted;
  logic [bga_pkg::SUM_W-1:0]    window_sum;
  int unsigned                  window_fill;
  gauge_reading_t               readings_due[$];
  int unsigned                  mismatch_cnt;

  // Idling switches for the sample sender and the result receiver
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic int unsigned charge_pct(input int unsigned mv);
    if (mv >= CURVE_FULL_MV) return 100;
    if (mv >= CURVE_MID_MV)  return 50 + (mv - CURVE_MID_MV) / 6;
    if (mv >= CURVE_LOW_MV)  return (mv - CURVE_LOW_MV) / 8;
    return 0;
  endfunction

  // Reading for a closed window: truncated average, scale to ADC millivolts,
  // then apply the Q8 divider ratio. Thresholds see the full-width voltage.
  function automatic gauge_reading_t reading_for_sum(
    input logic [bga_pkg::SUM_W-1:0] total
  );
    int unsigned avg;
    int unsigned adc_mv;
    int unsigned mv;
    gauge_reading_t r;
    avg    = total / bga_pkg::SAMPLES;
    adc_mv = (avg * VREF_MV) / ADC_FULL;
    mv     = (adc_mv * ratio_q8) >> 8;
    if (!circuit_fitted) begin
      r.mv  = '0;
      r.pct = '0;
      r.st  = bga_pkg::ST_NO_CIRCUIT;
    end else if (mv <= present_mv) begin
      r.mv  = bga_pkg::MV_OUT_W'(mv);
      r.pct = '0;
      r.st  = bga_pkg::ST_NO_BATTERY;
    end else begin
      r.mv  = bga_pkg::MV_OUT_W'(mv);
      r.pct = bga_pkg::PCT_W'(charge_pct(mv));
      if (mv <= critical_mv)  r.st = bga_pkg::ST_CRITICAL;
      else if (mv <= low_mv)  r.st = bga_pkg::ST_LOW;
      else                    r.st = bga_pkg::ST_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: follow every accepted beat on all three channels
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    gauge_reading_t want;
    if (rst_ni) begin
      // Register writes land in the local copy straight away; the block
      // applies them at the next window end, which is the same thing here
      // since writes only happen while no window is closing.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          bga_pkg::REG_DIVIDER_RATIO: ratio_q8       = cfg.data[bga_pkg::RATIO_W-1:0];
          bga_pkg::REG_CRITICAL_MV:   critical_mv    = cfg.data;
          bga_pkg::REG_LOW_MV:        low_mv         = cfg.data;
          bga_pkg::REG_PRESENT_MV:    present_mv     = cfg.data;
          bga_pkg::REG_CIRCUIT:       circuit_fitted = cfg.data[0];
          default: ;
        endcase
      end

      // Accumulate; queue a reading when the window closes
      if (smp.valid && smp.ready) begin
        window_sum  = window_sum + smp.sample;
        window_fill = window_fill + 1;
        if (window_fill == bga_pkg::SAMPLES) begin
          readings_due.push_back(reading_for_sum(window_sum));
          window_sum  = '0;
          window_fill = 0;
        end
      end

      // Compare each delivered reading with the oldest one due
      if (res.valid && res.ready) begin
        if (readings_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: reading with none due: mv=%0d pct=%0d status=%0d",
                     $realtime, res.battery_mv, res.percent, res.status);
        end else begin
          want = readings_due.pop_front();
          if (want.mv !== res.battery_mv || want.pct !== res.percent ||
              want.st !== res.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: expected mv=%0d pct=%0d status=%0d, got mv=%0d pct=%0d status=%0d",
                       $realtime, want.mv, want.pct, want.st,
                       res.battery_mv, res.percent, res.status);
          end
        end
      end
    end
  end

  // Receiver: stall about a third of the time unless told to run steady
  always @(posedge clk_i) begin
    res.ready <= !sink_gaps || ($urandom_range(99) >= 33);
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one sample beat. Valid is left high after the handshake so that
  // back-to-back beats never lower and raise it within one step; drop it
  // only in an idle cycle or through release_samples.
  task automatic send_sample(input logic [bga_pkg::SAMPLE_W-1:0] val);
    while (src_gaps && $urandom_range(99) < 33) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.sample <= val;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  task automatic release_samples();
    smp.valid <= 1'b0;
  endtask

  // Register write beat; same rule for valid as on the sample channel
  task automatic write_reg(input logic [bga_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [bga_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  task automatic release_regs();
    cfg.valid <= 1'b0;
  endtask

  // Hold until every reading due has come, then give a partly filled
  // window time to finish its accumulate step
  task automatic settle();
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_flat_window(input logic [bga_pkg::SAMPLE_W-1:0] val);
    for (int i = 0; i < bga_pkg::SAMPLES; i++) send_sample(val);
  endtask

  function automatic logic [bga_pkg::CFG_DATA_W-1:0] any_mv();
    // Mostly inside the specified span, sometimes anywhere in the field
    if ($urandom_range(3) == 0) return bga_pkg::CFG_DATA_W'($urandom);
    return bga_pkg::CFG_DATA_W'($urandom_range(MV_SPAN));
  endfunction

  // Write all five registers, plus now and then a write past the list
  task automatic program_gauge(input logic [bga_pkg::CFG_DATA_W-1:0] ratio,
                               input logic [bga_pkg::CFG_DATA_W-1:0] crit,
                               input logic [bga_pkg::CFG_DATA_W-1:0] low,
                               input logic [bga_pkg::CFG_DATA_W-1:0] pres,
                               input logic [bga_pkg::CFG_DATA_W-1:0] fitted);
    write_reg(bga_pkg::REG_DIVIDER_RATIO, ratio);
    if ($urandom_range(1))
      write_reg(bga_pkg::REG_CIRCUIT + 3'($urandom_range(3, 1)),
                bga_pkg::CFG_DATA_W'($urandom));
    write_reg(bga_pkg::REG_CRITICAL_MV, crit);
    write_reg(bga_pkg::REG_LOW_MV, low);
    write_reg(bga_pkg::REG_PRESENT_MV, pres);
    write_reg(bga_pkg::REG_CIRCUIT, fitted);
    release_regs();
  endtask

  task automatic program_random();
    program_gauge(bga_pkg::CFG_DATA_W'($urandom), any_mv(), any_mv(), any_mv(),
                  bga_pkg::CFG_DATA_W'(($urandom_range(5) != 0) | ($urandom & 16'hFFFE)));
  endtask

  // One window aimed at a voltage of interest: a knee, a threshold or
  // anywhere. Samples jitter a little about the matching ADC code; a few
  // windows are pure noise instead.
  task automatic send_aimed_window();
    longint aim;
    longint code;
    int     spread;
    int     v;
    case ($urandom_range(7))
      0:       aim = CURVE_LOW_MV;
      1:       aim = CURVE_MID_MV;
      2:       aim = CURVE_FULL_MV;
      3:       aim = critical_mv;
      4:       aim = low_mv;
      5:       aim = present_mv;
      default: aim = $urandom_range(MV_SPAN);
    endcase
    aim = aim + longint'($urandom_range(40)) - 20;
    if (ratio_q8 == 0) code = $urandom_range(ADC_FULL);
    else code = (aim * 256 * ADC_FULL) / (longint'(ratio_q8) * VREF_MV);
    if (code < 0) code = 0;
    if (code > ADC_FULL) code = ADC_FULL;
    spread = ($urandom_range(4) == 0) ? int'(ADC_FULL) : $urandom_range(6);
    for (int i = 0; i < bga_pkg::SAMPLES; i++) begin
      v = int'(code) + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > int'(ADC_FULL)) v = ADC_FULL;
      send_sample(bga_pkg::SAMPLE_W'(v));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings: a full-scale window reads well above the top knee,
  // an all-zero window reads as no battery
  task automatic test_extremes();
    send_flat_window(bga_pkg::SAMPLE_W'(ADC_FULL));
    send_flat_window('0);
    release_samples();
    settle();
  endtask

  // Circuit absent: the window still closes but reports nothing measured.
  // Also drop a write past the end of the register list in first.
  task automatic test_no_circuit();
    write_reg(bga_pkg::REG_CIRCUIT + 3'd3, '1);
    write_reg(bga_pkg::REG_CIRCUIT, bga_pkg::CFG_DATA_W'(0));
    release_regs();
    send_flat_window(bga_pkg::SAMPLE_W'(12'h800));
    release_samples();
    settle();
  endtask

  // Several register settings, extremes first, then random ones
  task automatic test_settings_sweep();
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: program_gauge('0, any_mv(), any_mv(), any_mv(), bga_pkg::CFG_DATA_W'(1));
        1: program_gauge('1, '1, '1, '1, '1);
        2: program_gauge(bga_pkg::CFG_DATA_W'(2047), '0, '0, '0, bga_pkg::CFG_DATA_W'(1));
        3: program_gauge(bga_pkg::CFG_DATA_W'(2047), bga_pkg::CFG_DATA_W'(MV_SPAN),
                         bga_pkg::CFG_DATA_W'(MV_SPAN), '0, bga_pkg::CFG_DATA_W'(1));
        4: program_gauge(bga_pkg::CFG_DATA_W'($urandom), any_mv(), any_mv(), any_mv(), '0);
        default: program_random();
      endcase
      for (int w = 0; w < 12; w++) send_aimed_window();
      release_samples();
      settle();
    end
  endtask

  // Write the registers with a window part filled; the new values must
  // only show at the window end
  task automatic test_mid_window_write();
    for (int k = 0; k < 3; k++) begin
      repeat ($urandom_range(bga_pkg::SAMPLES - 1, 1))
        send_sample(bga_pkg::SAMPLE_W'($urandom));
      release_samples();
      settle();
      program_random();
      for (int w = 0; w < 2; w++) send_aimed_window();
      release_samples();
      settle();
    end
  endtask

  // Long run with no idling on either side
  task automatic test_steady_stream();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    program_random();
    for (int w = 0; w < 15; w++) send_aimed_window();
    release_samples();
    settle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    rst_ni     <= 1'b0;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= '0;
    cfg.data   <= '0;

    // Reset state of the local copy
    ratio_q8       = bga_pkg::RATIO_W'(512);
    critical_mv    = bga_pkg::MV_OUT_W'(3300);
    low_mv         = bga_pkg::MV_OUT_W'(3500);
    present_mv     = bga_pkg::MV_OUT_W'(2500);
    circuit_fitted = 1'b1;
    window_sum     = '0;
    window_fill    = 0;
    mismatch_cnt   = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_no_circuit();
    test_settings_sweep();
    test_mid_window_write();
    test_steady_stream();

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bga_pkg.sv
rtl/core/bga_if.sv
rtl/core/bga_seq.sv
rtl/core/battery_gauge_averager_top.sv
verif/battery_gauge_averager_top_tb.sv
